// ----- design/pcdf_pkg.sv -----
// Shared constants and types of the pulse capture duty and frequency core.
`default_nettype none
package pcdf_pkg;

  localparam int TICK_W  = 27;
  localparam int STAMP_W = 16;
  localparam int CH_W    = 2;
  localparam int FRAC_W  = 16;

  localparam logic [TICK_W-1:0] TICK_RESET = 27'd1000000;
  localparam logic [FRAC_W-1:0] DUTY_MAX   = 16'hFFFF;

  localparam logic [CH_W-1:0] CH_FREQ   = 2'd0;
  localparam logic [CH_W-1:0] CH_DUTY_A = 2'd1;
  localparam logic [CH_W-1:0] CH_DUTY_B = 2'd2;
  localparam logic [CH_W-1:0] CH_UNUSED = 2'd3;

  localparam logic [1:0] PH_WAIT   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ----- design/pulse_capture_duty_frequency_core.sv -----
// Pulse capture core: frequency and duty measurement from timestamped edges.
//
// Input channel: valid/ready carrying channel and timestamp of one captured
// edge. Output channel: valid/ready carrying one result item per input item.
// Channel 0 measures period and frequency from one rising edge to the next; channels 1
// and 2 measure high time, low time and Q0.16 duty over rising, falling,
// rising edges. next_edge_falling reports the polarity the channel wants next.
// cfg_write/cfg_data load the counter tick rate; write only while idle.
// An edge that completes a measurement with a nonzero divisor runs the shared
// serial divider, one quotient bit per cycle over max(27, COUNTER_BITS + 16)
// bits: 32 steps at the default width. Its start pulse is registered, and the
// quotient goes to the pending result. Other edges go straight to the pending
// result, which the output register then takes. One item is worked on at a
// time; in_ready is high whenever the sequencer is idle, also while a finished
// result still waits at the output. A stalled receiver holds the output
// register and then the pending result; no item is lost.
// Reset (synchronous, active high) clears all channel phases, stamps and held
// high times, drops any result, and sets the tick rate to 1000000.
`default_nettype none
module pulse_capture_duty_frequency_core
  import pcdf_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [TICK_W-1:0]  cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CH_W-1:0]    channel,
  input  wire logic [STAMP_W-1:0] timestamp,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [CH_W-1:0]    out_channel,
  output logic                    done_res,
  output logic                    next_edge_falling,
  output logic      [STAMP_W-1:0] period_ticks,
  output logic      [TICK_W-1:0]  frequency_hz,
  output logic      [STAMP_W-1:0] high_ticks,
  output logic      [STAMP_W-1:0] low_ticks,
  output logic      [FRAC_W-1:0]  duty_q16
);

  localparam int CB    = COUNTER_BITS;
  localparam int DEN_W = CB + 1;
  localparam int NUM_W = (TICK_W > CB + FRAC_W) ? TICK_W : CB + FRAC_W;

  typedef enum logic [1:0] {IDLE, DIVIDE, HOLD} state_t;

  state_t            state;
  logic [TICK_W-1:0] tick_rate_hz;
  logic [1:0]        phase [3];
  logic [CB-1:0]     start_stamp [3];
  logic [CB-1:0]     held_high_time [2];

  logic [CH_W-1:0]   p_ch;
  logic              p_done;
  logic              p_fall;
  logic              p_is_freq;
  logic [STAMP_W-1:0] p_period;
  logic [STAMP_W-1:0] p_hi;
  logic [STAMP_W-1:0] p_lo;
  logic [TICK_W-1:0] p_freq;
  logic [FRAC_W-1:0] p_duty;

  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [NUM_W-1:0]  div_quot;
  div_stat_t         div_stat;

  logic              accept;
  logic [CB-1:0]     ts;
  logic [CB-1:0]     diff_now;
  logic [CB-1:0]     hi_now;
  logic [DEN_W-1:0]  sum_now;
  logic [1:0]        ph_now;
  logic [FRAC_W-1:0] duty_sat;
  logic              freq_done;
  logic              duty_done;
  logic              fall_now;
  logic              div_go;
  logic              out_load;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign ts       = CB'(timestamp);

  always_comb begin
    ph_now    = (channel == CH_UNUSED) ? PH_WAIT : phase[channel];
    diff_now  = (channel == CH_UNUSED) ? '0 : ts - start_stamp[channel];
    hi_now    = held_high_time[channel[1]];
    sum_now   = {1'b0, hi_now} + {1'b0, diff_now};
    duty_sat  = (|div_quot[NUM_W-1:FRAC_W]) ? DUTY_MAX : div_quot[FRAC_W-1:0];
    freq_done = (channel == CH_FREQ) && (ph_now == PH_FIRST);
    duty_done = (channel == CH_DUTY_A || channel == CH_DUTY_B) && (ph_now == PH_SECOND);
    fall_now  = (channel == CH_DUTY_A || channel == CH_DUTY_B) &&
                (ph_now != PH_FIRST) && (ph_now != PH_SECOND);
    div_go    = (freq_done && (diff_now != '0)) || (duty_done && (sum_now != '0));
    out_load  = (state == HOLD) && (!out_valid || out_ready);
  end

  pcdf_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quot (div_quot),
    .stat (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      tick_rate_hz   <= TICK_RESET;
      phase          <= '{default: PH_WAIT};
      start_stamp    <= '{default: '0};
      held_high_time <= '{default: '0};
      div_start      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      div_start <= accept && div_go;
      out_valid <= out_load || (out_valid && !out_ready);
      if (cfg_write) begin
        tick_rate_hz <= cfg_data;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            p_ch      <= channel;
            p_done    <= freq_done || duty_done;
            p_fall    <= fall_now;
            p_is_freq <= freq_done;
            p_period  <= freq_done ? STAMP_W'(diff_now) : '0;
            p_hi      <= duty_done ? STAMP_W'(hi_now) : '0;
            p_lo      <= duty_done ? STAMP_W'(diff_now) : '0;
            p_freq    <= '0;
            p_duty    <= '0;
            state     <= div_go ? DIVIDE : HOLD;
            if (channel == CH_FREQ) begin
              if (freq_done) begin
                phase[0] <= PH_WAIT;
                div_num  <= NUM_W'(tick_rate_hz);
                div_den  <= DEN_W'(diff_now);
              end else begin
                start_stamp[0] <= ts;
                phase[0]       <= PH_FIRST;
              end
            end else if (channel != CH_UNUSED) begin
              if (ph_now == PH_FIRST) begin
                held_high_time[channel[1]] <= diff_now;
                start_stamp[channel]       <= ts;
                phase[channel]             <= PH_SECOND;
              end else if (duty_done) begin
                phase[channel] <= PH_WAIT;
                div_num        <= NUM_W'({hi_now, {FRAC_W{1'b0}}});
                div_den        <= sum_now;
              end else begin
                start_stamp[channel] <= ts;
                phase[channel]       <= PH_FIRST;
              end
            end
          end
        end
        DIVIDE: begin
          if (div_stat.done) begin
            if (p_is_freq) begin
              p_freq <= div_quot[TICK_W-1:0];
            end else begin
              p_duty <= duty_sat;
            end
            state <= HOLD;
          end
        end
        HOLD: begin
          if (out_load) begin
            out_channel       <= p_ch;
            done_res          <= p_done;
            next_edge_falling <= p_fall;
            period_ticks      <= p_period;
            frequency_hz      <= p_freq;
            high_ticks        <= p_hi;
            low_ticks         <= p_lo;
            duty_q16          <= p_duty;
            state             <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != IDLE)
    else $error("accepted item did not start the sequencer");

  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == DIVIDE)
    else $error("divider finished outside the divide step");

  a_incomplete_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> period_ticks == '0 && frequency_hz == '0 &&
      high_ticks == '0 && low_ticks == '0 && duty_q16 == '0)
    else $error("incomplete measurement carries nonzero fields");

  a_freq_no_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_channel == CH_FREQ |-> high_ticks == '0 &&
      low_ticks == '0 && duty_q16 == '0 && !next_edge_falling)
    else $error("frequency result carries duty fields");

  a_unused_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_channel == CH_UNUSED |-> !done_res && !next_edge_falling)
    else $error("unused channel reported activity");

endmodule
`default_nettype wire

// ----- design/pcdf_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module pcdf_div
  import pcdf_pkg::*;
#(
  parameter int NUM_W = 32,
  parameter int DEN_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quot,
  output div_stat_t             stat
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] count;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             qbit;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    rem_sh   = {rem, quot[NUM_W-1]};
    diff     = rem_sh - {1'b0, den};
    qbit     = ~diff[DEN_W];
    rem_next = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      count <= '0;
    end else begin
      stat.done <= !start && stat.busy && (count == LAST);
      if (start) begin
        rem       <= '0;
        quot      <= num;
        count     <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem   <= rem_next;
        quot  <= {quot[NUM_W-2:0], qbit};
        count <= count + 1'b1;
        if (count == LAST) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_pulse_capture_duty_frequency_core.sv -----
// Testbench of the pulse capture core: directed table and random edges checked against a predictor.
`timescale 1ns / 1ps
module tb_pulse_capture_duty_frequency_core;
  import pcdf_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 165;
  localparam int NUM_PHASES = 8;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE = 40;
  localparam int MAX_PRINTS = 60;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic               done;
    logic               falling;
    logic [STAMP_W-1:0] period;
    logic [TICK_W-1:0]  freq;
    logic [STAMP_W-1:0] hi;
    logic [STAMP_W-1:0] lo;
    logic [FRAC_W-1:0]  duty;
  } meas_t;

  typedef struct {
    logic [CH_W-1:0]    ch;
    logic [STAMP_W-1:0] ts;
    bit                 typed;
    meas_t              want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [TICK_W-1:0]  cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [CH_W-1:0]    channel;
  logic [STAMP_W-1:0] timestamp;
  logic               out_valid;
  logic               out_ready;
  logic [CH_W-1:0]    out_channel;
  logic               done_res;
  logic               next_edge_falling;
  logic [STAMP_W-1:0] period_ticks;
  logic [TICK_W-1:0]  frequency_hz;
  logic [STAMP_W-1:0] high_ticks;
  logic [STAMP_W-1:0] low_ticks;
  logic [FRAC_W-1:0]  duty_q16;

  // predictor state
  logic [TICK_W-1:0]  tick_m;
  logic [1:0]         phase_m [3];
  logic [STAMP_W-1:0] stamp_m [3];
  logic [STAMP_W-1:0] high_m  [2];

  meas_t              meas_q [$];
  row_t               dir_tab [$];
  logic [STAMP_W-1:0] last_ts [4];
  int                 mismatch_cnt = 0;
  int                 cycle_cnt = 0;
  bit                 idle_on = 1'b1;
  bit                 long_hold = 1'b0;

  pulse_capture_duty_frequency_core i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .channel           (channel),
    .timestamp         (timestamp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel       (out_channel),
    .done_res          (done_res),
    .next_edge_falling (next_edge_falling),
    .period_ticks      (period_ticks),
    .frequency_hz      (frequency_hz),
    .high_ticks        (high_ticks),
    .low_ticks         (low_ticks),
    .duty_q16          (duty_q16)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic meas_t measure_edge(input logic [CH_W-1:0] ch,
                                         input logic [STAMP_W-1:0] ts);
    meas_t     r;
    logic [16:0] sum;
    logic [32:0] q;
    int        h;
    r = '0;
    r.ch = ch;
    case (ch)
      CH_FREQ: begin
        if (phase_m[0] == PH_FIRST) begin
          r.period = ts - stamp_m[0];
          r.freq = (r.period == '0) ? '0 : tick_m / r.period;
          phase_m[0] = PH_WAIT;
          r.done = 1'b1;
        end else begin
          stamp_m[0] = ts;
          phase_m[0] = PH_FIRST;
        end
      end
      CH_DUTY_A, CH_DUTY_B: begin
        h = int'(ch) - 1;
        if (phase_m[ch] == PH_FIRST) begin
          high_m[h] = ts - stamp_m[ch];
          stamp_m[ch] = ts;
          phase_m[ch] = PH_SECOND;
        end else if (phase_m[ch] == PH_SECOND) begin
          r.hi = high_m[h];
          r.lo = ts - stamp_m[ch];
          sum = {1'b0, r.hi} + {1'b0, r.lo};
          if (sum != '0) begin
            q = {1'b0, r.hi, 16'h0000} / sum;
            r.duty = (q > DUTY_MAX) ? DUTY_MAX : q[FRAC_W-1:0];
          end
          phase_m[ch] = PH_WAIT;
          r.done = 1'b1;
        end else begin
          stamp_m[ch] = ts;
          phase_m[ch] = PH_FIRST;
          r.falling = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic row_t row(input logic [CH_W-1:0] ch, input logic [STAMP_W-1:0] ts,
                               input bit typed, input logic done, input logic falling,
                               input logic [STAMP_W-1:0] period, input logic [TICK_W-1:0] freq,
                               input logic [STAMP_W-1:0] hi, input logic [STAMP_W-1:0] lo,
                               input logic [FRAC_W-1:0] duty);
    row_t r;
    r.ch = ch;
    r.ts = ts;
    r.typed = typed;
    r.want = '{ch: ch, done: done, falling: falling, period: period, freq: freq,
               hi: hi, lo: lo, duty: duty};
    return r;
  endfunction

  function automatic logic [STAMP_W-1:0] next_stamp(input logic [CH_W-1:0] ch);
    logic [STAMP_W-1:0] ts;
    case ($urandom_range(0, 9))
      0:       ts = last_ts[ch];
      1:       ts = last_ts[ch] + 16'd1;
      2:       ts = last_ts[ch] - 16'd1;
      3, 4, 5: ts = last_ts[ch] + 16'($urandom_range(1, 64));
      6:       ts = $urandom_range(0, 1) ? '0 : '1;
      default: ts = 16'($urandom_range(0, 65535));
    endcase
    last_ts[ch] = ts;
    return ts;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic send_edge(input logic [CH_W-1:0] ch, input logic [STAMP_W-1:0] ts,
                           input bit typed, input meas_t want);
    int    gap;
    meas_t m;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= ch;
    timestamp <= ts;
    do @(posedge clk); while (in_ready !== 1'b1);
    m = measure_edge(ch, ts);
    meas_q.push_back(typed ? want : m);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (meas_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_tick(input logic [TICK_W-1:0] value);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    tick_m = value;
  endtask

  // receiver
  initial begin
    int    gap;
    meas_t got;
    meas_t want;
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = '{ch: out_channel, done: done_res, falling: next_edge_falling,
              period: period_ticks, freq: frequency_hz, hi: high_ticks,
              lo: low_ticks, duty: duty_q16};
      if (meas_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = meas_q.pop_front();
        check_field("out_channel", got.ch, want.ch);
        check_field("done_res", got.done, want.done);
        check_field("next_edge_falling", got.falling, want.falling);
        check_field("period_ticks", got.period, want.period);
        check_field("frequency_hz", got.freq, want.freq);
        check_field("high_ticks", got.hi, want.hi);
        check_field("low_ticks", got.lo, want.lo);
        check_field("duty_q16", got.duty, want.duty);
      end
    end
  end

  // sender
  initial begin
    logic [CH_W-1:0]    ch;
    logic [STAMP_W-1:0] ts;
    logic [TICK_W-1:0]  tick;
    int                 cnt;
    bit                 paused;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    channel <= '0;
    timestamp <= '0;
    tick_m = TICK_RESET;
    for (int i = 0; i < 3; i++) begin
      phase_m[i] = PH_WAIT;
      stamp_m[i] = '0;
    end
    high_m[0] = '0;
    high_m[1] = '0;
    for (int i = 0; i < 4; i++) last_ts[i] = '0;

    dir_tab.push_back(row(CH_UNUSED, 16'hFFFF, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_FREQ,   16'h0000, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_FREQ,   16'h0000, 1, 1, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_FREQ,   16'hFFFF, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_FREQ,   16'h0000, 1, 1, 0, 1, 1000000, 0, 0, 0));
    dir_tab.push_back(row(CH_FREQ,   16'h0000, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_FREQ,   16'hFFFF, 1, 1, 0, 16'hFFFF, 15, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_A, 16'h1000, 1, 0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_A, 16'h1000, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_A, 16'h1000, 1, 1, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_B, 16'hFFFF, 1, 0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_B, 16'h0009, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_B, 16'h0009, 1, 1, 0, 0, 0, 10, 0, DUTY_MAX));
    dir_tab.push_back(row(CH_UNUSED, 16'h0000, 1, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_A, 16'h0000, 1, 0, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_A, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_A, 16'hFFFE, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_B, 16'h5555, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_B, 16'hAAAA, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_B, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_FREQ,   16'h1234, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_A, 16'h0100, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_FREQ,   16'h2345, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_A, 16'h0180, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(row(CH_DUTY_A, 16'h0200, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_edge(dir_tab[i].ch, dir_tab[i].ts, dir_tab[i].typed,
                                   dir_tab[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       tick = 27'd1;
        1:       tick = 27'd100000000;
        2:       tick = '0;
        3:       tick = '1;
        4:       tick = TICK_RESET;
        default: tick = 27'($urandom_range(1, 100000000));
      endcase
      load_tick(tick);
      idle_on = (p != 2);
      if (p == 3) long_hold = 1'b1;
      cnt = 0;
      paused = 1'b0;
      while (cnt < PHASE_ITEMS) begin
        if (!paused && p % 2 == 1 && cnt >= PHASE_ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        ch = ($urandom_range(0, 19) == 0) ? CH_UNUSED : CH_W'($urandom_range(0, 2));
        ts = next_stamp(ch);
        send_edge(ch, ts, 0, '0);
        if (ch != CH_UNUSED) cnt++;
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
